>>> src/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only while out of reset.
`define MFLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every edge, reset included.
`define MFLD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/mfld_pkg.sv
`default_nettype none

package mfld_pkg;

  localparam int SCREEN_WIDTH_DEF  = 128;
  localparam int SCREEN_HEIGHT_DEF = 64;
  localparam int FRAME_BYTES       = 1024;
  localparam int ADDR_W            = $clog2(FRAME_BYTES);
  localparam int ROW_BYTES         = 128 / 8;
  localparam int ROW_SHIFT         = $clog2(ROW_BYTES);
  localparam logic [7:0] MSB_MASK  = 8'h80;
  localparam int QUEUE_DEPTH       = 2;

  localparam logic OPC_DRAW = 1'b0;
  localparam logic OPC_READ = 1'b1;

  typedef enum logic [1:0] {
    PIX_CLEAR  = 2'd0,
    PIX_SET    = 2'd1,
    PIX_TOGGLE = 2'd2,
    PIX_KEEP   = 2'd3
  } pix_op_t;

  // Classified word as it sits in the queue.
  typedef struct packed {
    logic              is_read;
    logic [7:0]        x0;
    logic [7:0]        y0;
    logic [7:0]        x1;
    logic [7:0]        y1;
    pix_op_t           op;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        dx;
    logic [7:0]        dy;
    logic              x_dec;
    logic              y_dec;
  } mfld_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } mfld_qstat_t;

endpackage

`default_nettype wire

>>> src/mfld_front.sv
`default_nettype none

module mfld_front (
  input  logic                  start,
  input  logic                  busy,
  input  logic                  in_opcode,
  input  logic [7:0]            in_start_x,
  input  logic [7:0]            in_start_y,
  input  logic [7:0]            in_end_x,
  input  logic [7:0]            in_end_y,
  input  logic [1:0]            in_pixel_op,
  input  logic [9:0]            in_read_address,
  output logic                  push,
  output mfld_pkg::mfld_item_t  item
);
  import mfld_pkg::*;

  logic x_up;
  logic y_up;

  assign push = start && !busy;
  assign x_up = in_start_x < in_end_x;
  assign y_up = in_start_y < in_end_y;

  always_comb begin
    item.is_read = (in_opcode == OPC_READ);
    item.x0      = in_start_x;
    item.y0      = in_start_y;
    item.x1      = in_end_x;
    item.y1      = in_end_y;
    item.op      = pix_op_t'(in_pixel_op);
    item.addr    = in_read_address;
    item.dx      = x_up ? (in_end_x - in_start_x) : (in_start_x - in_end_x);
    item.dy      = y_up ? (in_end_y - in_start_y) : (in_start_y - in_end_y);
    item.x_dec   = !x_up;
    item.y_dec   = !y_up;
  end

endmodule

`default_nettype wire

>>> src/mfld_queue.sv
`default_nettype none

module mfld_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  mfld_pkg::mfld_item_t  push_item,
  input  logic                  pop,
  output mfld_pkg::mfld_item_t  head_item,
  output mfld_pkg::mfld_qstat_t qstat
);
  import mfld_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  mfld_item_t        slots_r [QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
    if (push) begin
      slots_r[wr_ptr_r] <= push_item;
    end
  end

  assign head_item   = slots_r[rd_ptr_r];
  assign qstat.full  = (count_r == CNT_FULL);
  assign qstat.empty = (count_r == '0);

endmodule

`default_nettype wire

>>> src/mfld_back.sv
`default_nettype none

module mfld_back #(
  parameter int SCREEN_WIDTH  = mfld_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = mfld_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  q_empty,
  input  mfld_pkg::mfld_item_t  q_item,
  output logic                  pop,
  output logic                  clearing,
  output logic                  out_valid,
  output logic [7:0]            out_read_data
);
  import mfld_pkg::*;

  localparam logic [8:0] W_LIM = 9'(SCREEN_WIDTH);
  localparam logic [8:0] H_LIM = 9'(SCREEN_HEIGHT);
  localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(FRAME_BYTES - 1);

  typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_WALK} state_t;

  logic [7:0] frame_mem [FRAME_BYTES];

  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] clr_cnt_r, clr_cnt_nxt;

  // line walker
  logic [7:0]        x_r, x_nxt, y_r, y_nxt;
  logic [7:0]        x1_r, x1_nxt, y1_r, y1_nxt;
  logic [7:0]        dx_r, dx_nxt, dy_r, dy_nxt;
  logic              x_dec_r, x_dec_nxt, y_dec_r, y_dec_nxt;
  pix_op_t           op_r, op_nxt;
  logic signed [10:0] err_r, err_nxt;

  // read-modify-write stage
  logic              s2_valid_r, s2_valid_nxt;
  logic              s2_last_r, s2_last_nxt;
  logic              s2_is_read_r, s2_is_read_nxt;
  logic              s2_write_r, s2_write_nxt;
  logic [ADDR_W-1:0] s2_addr_r, s2_addr_nxt;
  logic [7:0]        s2_mask_r, s2_mask_nxt;
  pix_op_t           s2_op_r, s2_op_nxt;

  logic              wr_valid_r, wr_valid_nxt;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [7:0]        wr_data_r;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;

  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        mem_rd_r;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;
  logic [7:0]        mem_wdata;

  logic              pix_on, at_end, take_x, take_y;
  logic [ADDR_W-1:0] pix_addr;
  logic [7:0]        pix_mask;
  logic signed [11:0] e2;
  logic signed [10:0] dx11, dy11;
  logic [7:0]        cur_byte, new_byte;

  assign pix_on   = ({1'b0, x_r} < W_LIM) && ({1'b0, y_r} < H_LIM);
  assign pix_addr = ADDR_W'({y_r, {ROW_SHIFT{1'b0}}}) + ADDR_W'(x_r >> 3);
  assign pix_mask = MSB_MASK >> x_r[2:0];
  assign at_end   = (x_r == x1_r) && (y_r == y1_r);
  assign dx11     = signed'({3'b000, dx_r});
  assign dy11     = signed'({3'b000, dy_r});
  assign e2       = {err_r, 1'b0};
  assign take_x   = e2 > -signed'({4'b0000, dy_r});
  assign take_y   = e2 < signed'({4'b0000, dx_r});

  // forward the byte written in the previous cycle; the memory read missed it
  assign cur_byte = (wr_valid_r && wr_addr_r == s2_addr_r) ? wr_data_r : mem_rd_r;

  always_comb begin
    case (s2_op_r)
      PIX_CLEAR:  new_byte = cur_byte & ~s2_mask_r;
      PIX_SET:    new_byte = cur_byte | s2_mask_r;
      PIX_TOGGLE: new_byte = cur_byte ^ s2_mask_r;
      default:    new_byte = cur_byte;
    endcase
  end

  assign pop      = (state_r == ST_IDLE) && !q_empty;
  assign clearing = (state_r == ST_CLEAR);

  always_comb begin
    state_nxt      = state_r;
    clr_cnt_nxt    = clr_cnt_r;
    x_nxt          = x_r;
    y_nxt          = y_r;
    x1_nxt         = x1_r;
    y1_nxt         = y1_r;
    dx_nxt         = dx_r;
    dy_nxt         = dy_r;
    x_dec_nxt      = x_dec_r;
    y_dec_nxt      = y_dec_r;
    op_nxt         = op_r;
    err_nxt        = err_r;
    s2_valid_nxt   = 1'b0;
    s2_last_nxt    = 1'b0;
    s2_is_read_nxt = 1'b0;
    s2_write_nxt   = 1'b0;
    s2_addr_nxt    = pix_addr;
    s2_mask_nxt    = pix_mask;
    s2_op_nxt      = op_r;
    rd_en          = 1'b0;
    rd_addr        = pix_addr;
    case (state_r)
      ST_CLEAR: begin
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (pop) begin
          if (q_item.is_read) begin
            rd_en          = 1'b1;
            rd_addr        = q_item.addr;
            s2_valid_nxt   = 1'b1;
            s2_last_nxt    = 1'b1;
            s2_is_read_nxt = 1'b1;
            s2_addr_nxt    = q_item.addr;
          end else begin
            x_nxt     = q_item.x0;
            y_nxt     = q_item.y0;
            x1_nxt    = q_item.x1;
            y1_nxt    = q_item.y1;
            dx_nxt    = q_item.dx;
            dy_nxt    = q_item.dy;
            x_dec_nxt = q_item.x_dec;
            y_dec_nxt = q_item.y_dec;
            op_nxt    = q_item.op;
            err_nxt   = signed'({3'b000, q_item.dx}) - signed'({3'b000, q_item.dy});
            state_nxt = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        // one pixel per clock: fetch its byte, step toward the end point
        rd_en        = 1'b1;
        s2_valid_nxt = 1'b1;
        s2_last_nxt  = at_end;
        s2_write_nxt = pix_on && (op_r != PIX_KEEP);
        if (at_end) begin
          state_nxt = ST_IDLE;
        end else begin
          err_nxt = err_r - (take_x ? dy11 : 11'sd0) + (take_y ? dx11 : 11'sd0);
          if (take_x) begin
            x_nxt = x_dec_r ? x_r - 1'b1 : x_r + 1'b1;
          end
          if (take_y) begin
            y_nxt = y_dec_r ? y_r - 1'b1 : y_r + 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    if (state_r == ST_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt_r;
      mem_wdata = '0;
    end else begin
      mem_we    = s2_valid_r && s2_write_r;
      mem_waddr = s2_addr_r;
      mem_wdata = new_byte;
    end
    wr_valid_nxt  = s2_valid_r && s2_write_r;
    out_valid_nxt = s2_valid_r && s2_last_r;
    out_data_nxt  = s2_is_read_r ? cur_byte : '0;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame_mem[mem_waddr] <= mem_wdata;
    end
    if (rd_en) begin
      mem_rd_r <= frame_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      s2_valid_r  <= 1'b0;
      wr_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      s2_valid_r  <= s2_valid_nxt;
      wr_valid_r  <= wr_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
    x_r          <= x_nxt;
    y_r          <= y_nxt;
    x1_r         <= x1_nxt;
    y1_r         <= y1_nxt;
    dx_r         <= dx_nxt;
    dy_r         <= dy_nxt;
    x_dec_r      <= x_dec_nxt;
    y_dec_r      <= y_dec_nxt;
    op_r         <= op_nxt;
    err_r        <= err_nxt;
    s2_last_r    <= s2_last_nxt;
    s2_is_read_r <= s2_is_read_nxt;
    s2_write_r   <= s2_write_nxt;
    s2_addr_r    <= s2_addr_nxt;
    s2_mask_r    <= s2_mask_nxt;
    s2_op_r      <= s2_op_nxt;
    wr_addr_r    <= mem_waddr;
    wr_data_r    <= mem_wdata;
    out_data_r   <= out_data_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_read_data = out_data_r;

endmodule

`default_nettype wire

>>> src/mono_framebuffer_line_drawer_unit.sv
`default_nettype none

// Monochrome 128x64 framebuffer with a Bresenham line drawer. Pulse start
// with busy low to hand over a word: in_opcode 0 draws the line from
// (in_start_x, in_start_y) to (in_end_x, in_end_y), both ends included,
// applying in_pixel_op (clear/set/toggle/none) to every on-screen pixel;
// in_opcode 1 reads the byte at in_read_address (row*16 + column/8, MSB is
// the leftmost pixel). Every word gives exactly one result: out_valid is high
// for one cycle with out_read_data (zero after a draw). The receiver cannot
// stall, so sample out_read_data whenever out_valid is seen. After reset busy
// stays high while the frame memory is swept to zero, one byte per clock.
// Words go into a 2-deep queue; busy is high when it is full. The back end
// takes one word at a time from the queue: a read fetches its byte through
// the read-modify-write stage into the out_read_data register; a line of
// n = max(|dx|, |dy|) + 1 pixels gives its result once its last pixel has
// passed that stage, and no new word is picked up until its walk ends. The
// frame memory has one read and one write port: one pixel read-modify-write
// per clock; back-to-back pixels in the same byte are forwarded.
module mono_framebuffer_line_drawer_unit #(
  parameter int SCREEN_WIDTH  = mfld_pkg::SCREEN_WIDTH_DEF,
  parameter int SCREEN_HEIGHT = mfld_pkg::SCREEN_HEIGHT_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_opcode,
  input  logic [7:0] in_start_x,
  input  logic [7:0] in_start_y,
  input  logic [7:0] in_end_x,
  input  logic [7:0] in_end_y,
  input  logic [1:0] in_pixel_op,
  input  logic [9:0] in_read_address,
  output logic       out_valid,
  output logic [7:0] out_read_data
);
  import mfld_pkg::*;

  mfld_item_t  front_item;
  mfld_item_t  head_item;
  mfld_qstat_t qstat;
  logic        push;
  logic        pop;
  logic        clearing;

  // hold off new words while the queue is full or memory is being cleared
  assign busy = qstat.full || clearing;

  mfld_front u_front (
    .start           (start),
    .busy            (busy),
    .in_opcode       (in_opcode),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_pixel_op     (in_pixel_op),
    .in_read_address (in_read_address),
    .push            (push),
    .item            (front_item)
  );

  mfld_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head_item (head_item),
    .qstat     (qstat)
  );

  // back end: memory clear sweep, line walker and read-modify-write stage
  mfld_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (qstat.empty),
    .q_item        (head_item),
    .pop           (pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_read_data (out_read_data)
  );

endmodule

`default_nettype wire

>>> src/mfld_checker.sv
`default_nettype none

`include "assert_macros.svh"

module mfld_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  logic [3:0] outstanding_r;
  logic       accept;

  assign accept = start && !busy;

  // words taken minus results given
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      outstanding_r <= '0;
    end else if (accept && !out_valid) begin
      outstanding_r <= outstanding_r + 1'b1;
    end else if (out_valid && !accept) begin
      outstanding_r <= outstanding_r - 1'b1;
    end
  end

  `MFLD_ASSERT_ALWAYS(a_busy_after_reset, (!rst_n) |=> busy, "busy low right after reset")
  `MFLD_ASSERT(a_clear_on_release, $rose(rst_n) |-> busy, "word taken during clear sweep")
  `MFLD_ASSERT(a_no_orphan_result, out_valid |-> (outstanding_r != 4'd0), "result without word")
  `MFLD_ASSERT(a_min_latency, (accept && outstanding_r == 4'd0) |=> !out_valid, "result too early")

endmodule

bind mono_framebuffer_line_drawer_unit mfld_checker u_mfld_checker (.*);

`default_nettype wire

>>> tb/mono_framebuffer_line_drawer_unit_tb.sv
`timescale 1ns / 1ps

module mono_framebuffer_line_drawer_unit_tb;
  import mfld_pkg::*;

  // One command word as the sender sees it. Each field maps onto its own port.
  typedef struct {
    logic       opcode;
    logic [7:0] sx;
    logic [7:0] sy;
    logic [7:0] ex;
    logic [7:0] ey;
    pix_op_t    op;
    logic [9:0] addr;
  } fb_word_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       start = 1'b0;
  logic       busy;
  logic       in_opcode = OPC_DRAW;
  logic [7:0] in_start_x = 8'h00;
  logic [7:0] in_start_y = 8'h00;
  logic [7:0] in_end_x = 8'h00;
  logic [7:0] in_end_y = 8'h00;
  logic [1:0] in_pixel_op = PIX_KEEP;
  logic [9:0] in_read_address = 10'h000;
  logic       out_valid;
  logic [7:0] out_read_data;

  // Shadow copy of the frame memory, updated in word order at acceptance.
  logic [7:0] frame_shadow [FRAME_BYTES];
  // Result bytes still owed by the block, oldest first.
  logic [7:0] owed_bytes [$];
  int         error_count = 0;
  // Byte holding the end point of the last random line that ends on screen; reads aim at it often.
  logic [9:0] last_end_addr = 10'h000;

  mono_framebuffer_line_drawer_unit i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_opcode      (in_opcode),
    .in_start_x     (in_start_x),
    .in_start_y     (in_start_y),
    .in_end_x       (in_end_x),
    .in_end_y       (in_end_y),
    .in_pixel_op    (in_pixel_op),
    .in_read_address(in_read_address),
    .out_valid      (out_valid),
    .out_read_data  (out_read_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog. The slowest legal run, the reset sweep and then ~1650 words of the
  // longest kind with the longest sender gaps, ends well inside the 10 ms limit.
  initial begin
    #10_000_000;
    $display("tb: failure");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Apply one pixel operation; off-screen pixels are dropped silently.
  function automatic void plot_pixel(input int x, input int y, input pix_op_t op);
    int         idx;
    logic [7:0] mask;
    if (x >= SCREEN_WIDTH_DEF || y >= SCREEN_HEIGHT_DEF) return;
    idx  = (y * ROW_BYTES + (x >> 3)) & (FRAME_BYTES - 1);
    mask = MSB_MASK >> (x & 7);
    case (op)
      PIX_CLEAR:  frame_shadow[idx] = frame_shadow[idx] & ~mask;
      PIX_SET:    frame_shadow[idx] = frame_shadow[idx] | mask;
      PIX_TOGGLE: frame_shadow[idx] = frame_shadow[idx] ^ mask;
      default:    ; // PIX_KEEP walks the line but leaves the pixel alone
    endcase
  endfunction

  // Integer Bresenham, both end points included; coordinates wrap at 256.
  function automatic void trace_line(input int ax, input int ay, input int bx,
                                     input int by, input pix_op_t op);
    int dx, dy, step_x, step_y, err, e2, n;
    dx     = (ax < bx) ? bx - ax : ax - bx;
    dy     = (ay < by) ? by - ay : ay - by;
    step_x = (ax < bx) ? 1 : -1;
    step_y = (ay < by) ? 1 : -1;
    err    = dx - dy;
    for (n = 0; n < 512; n++) begin
      plot_pixel(ax, ay, op);
      if (ax == bx && ay == by) break;
      e2 = 2 * err;
      if (e2 > -dy) begin
        err -= dy;
        ax = (ax + step_x) & 8'hFF;
      end
      if (e2 < dx) begin
        err += dx;
        ay = (ay + step_y) & 8'hFF;
      end
    end
  endfunction

  // Every word owes exactly one byte: the stored byte for a read, zero for a draw.
  function automatic void predict_word(input fb_word_t w);
    if (w.opcode == OPC_READ) begin
      owed_bytes.push_back(frame_shadow[w.addr]);
    end else begin
      trace_line(int'(w.sx), int'(w.sy), int'(w.ex), int'(w.ey), w.op);
      owed_bytes.push_back(8'h00);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Word builders. Fields a word ignores carry random garbage so that the block
  // is shown to really ignore them.
  // ---------------------------------------------------------------------------

  function automatic fb_word_t draw_word(input logic [7:0] sx, input logic [7:0] sy,
                                         input logic [7:0] ex, input logic [7:0] ey,
                                         input pix_op_t op);
    fb_word_t w;
    w.opcode = OPC_DRAW;
    w.sx     = sx;
    w.sy     = sy;
    w.ex     = ex;
    w.ey     = ey;
    w.op     = op;
    w.addr   = 10'($urandom_range(0, FRAME_BYTES - 1));
    return w;
  endfunction

  function automatic fb_word_t read_word(input logic [9:0] addr);
    fb_word_t w;
    w.opcode = OPC_READ;
    w.sx     = 8'($urandom_range(0, 255));
    w.sy     = 8'($urandom_range(0, 255));
    w.ex     = 8'($urandom_range(0, 255));
    w.ey     = 8'($urandom_range(0, 255));
    w.op     = pix_op_t'($urandom_range(0, 3));
    w.addr   = addr;
    return w;
  endfunction

  // Mostly short on-screen lines (keeps the run quick and the memory busy),
  // some screen-spanning ones, and a few anywhere in the 256x256 space.
  function automatic fb_word_t random_draw();
    logic [7:0] sx, sy, ex, ey;
    sx = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 127)) : 8'($urandom_range(0, 255));
    sy = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 63)) : 8'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        ex = 8'(sx + $urandom_range(0, 32) - 16);
        ey = 8'(sy + $urandom_range(0, 32) - 16);
      end
      6, 7, 8: begin
        ex = 8'($urandom_range(0, 127));
        ey = 8'($urandom_range(0, 63));
      end
      default: begin
        ex = 8'($urandom_range(0, 255));
        ey = 8'($urandom_range(0, 255));
      end
    endcase
    if (ex < SCREEN_WIDTH_DEF && ey < SCREEN_HEIGHT_DEF)
      last_end_addr = 10'(ey * ROW_BYTES + (ex >> 3));
    return draw_word(sx, sy, ex, ey, pix_op_t'($urandom_range(0, 3)));
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Present a word and hold it until an edge sees start high with busy low.
  // start stays high on return so back-to-back words need no low cycle.
  task automatic send_word(input fb_word_t w);
    start           <= 1'b1;
    in_opcode       <= w.opcode;
    in_start_x      <= w.sx;
    in_start_y      <= w.sy;
    in_end_x        <= w.ex;
    in_end_y        <= w.ey;
    in_pixel_op     <= w.op;
    in_read_address <= w.addr;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    predict_word(w);
  endtask

  task automatic idle_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Hold off until every owed byte has come back.
  task automatic wait_for_drain();
    start <= 1'b0;
    @(posedge clk);
    while (owed_bytes.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker: the block cannot be stalled, so take every strobe.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n === 1'b1 && out_valid !== 1'b0) begin
      if (owed_bytes.size() == 0) begin
        $error("read_data: no result owed, got %h", out_read_data);
        error_count++;
      end else begin
        want = owed_bytes.pop_front();
        if (out_valid !== 1'b1 || out_read_data !== want) begin
          $error("read_data: expected %h, got %h", want, out_read_data);
          error_count++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Frame memory must be all zero after the reset sweep.
  task automatic test_reset_state();
    send_word(read_word(10'h000));
    send_word(read_word(10'h3FF));
    send_word(read_word(10'h155));
    send_word(read_word(10'h2AA));
  endtask

  // Corner lines: screen diagonals, full 256-pixel lines that leave the screen,
  // single pixels, lines wholly off screen, and every pixel op.
  task automatic test_line_extremes();
    send_word(draw_word(8'd0, 8'd0, 8'd127, 8'd63, PIX_SET));
    send_word(read_word(10'd0));
    send_word(read_word(10'd1023));
    send_word(draw_word(8'd255, 8'd255, 8'd0, 8'd0, PIX_TOGGLE));
    send_word(read_word(10'd17));
    send_word(draw_word(8'd0, 8'd0, 8'd255, 8'd0, PIX_SET));
    send_word(read_word(10'd15));
    send_word(draw_word(8'd0, 8'd63, 8'd127, 8'd0, PIX_KEEP));
    send_word(read_word(10'd1008));
    send_word(draw_word(8'd0, 8'd0, 8'd0, 8'd63, PIX_CLEAR));
    send_word(read_word(10'd0));
    send_word(read_word(10'd1008));
    send_word(draw_word(8'd5, 8'd5, 8'd5, 8'd5, PIX_SET));
    send_word(read_word(10'd80));
    send_word(draw_word(8'd200, 8'd10, 8'd140, 8'd10, PIX_SET));
    send_word(draw_word(8'd127, 8'd0, 8'd0, 8'd255, PIX_TOGGLE));
    send_word(read_word(10'd15));
    send_word(draw_word(8'd255, 8'd0, 8'd0, 8'd255, PIX_TOGGLE));
    send_word(read_word(10'd127));
  endtask

  // Random traffic; idle_pct is the chance of a sender gap after a word.
  // Gaps are mostly short, now and then long enough to land mid-line.
  task automatic test_random_traffic(input int count, input int idle_pct);
    fb_word_t w;
    int       n;
    for (n = 0; n < count; n++) begin
      if ($urandom_range(0, 99) < 55) w = random_draw();
      else if ($urandom_range(0, 99) < 40) w = read_word(last_end_addr);
      else w = read_word(10'($urandom_range(0, FRAME_BYTES - 1)));
      send_word(w);
      if ($urandom_range(0, 99) < idle_pct)
        idle_sender(($urandom_range(0, 9) == 0) ? $urandom_range(20, 300)
                                                : $urandom_range(1, 6));
    end
  endtask

  initial begin
    for (int i = 0; i < FRAME_BYTES; i++) frame_shadow[i] = 8'h00;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_line_extremes();
    test_random_traffic(530, 33);
    wait_for_drain();
    test_random_traffic(530, 64);
    wait_for_drain();
    test_random_traffic(540, 0);

    // Drain, then linger past the longest line so a stray strobe is caught.
    wait_for_drain();
    repeat (300) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
